/* hw/rtl/frgcd_pkg.sv */
package frgcd_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] raw);
    logic [WIDTH-1:0] mag;
    mag = raw[WIDTH-1] ? (~raw + WIDTH'(1)) : raw;
    return mag;
  endfunction

endpackage

/* hw/rtl/frgcd_gcd.sv */
module frgcd_gcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [frgcd_pkg::WIDTH-1:0]  a_i,
  input  logic [frgcd_pkg::WIDTH-1:0]  b_i,
  output frgcd_pkg::unit_stat_t        stat_o,
  output logic [frgcd_pkg::WIDTH-1:0]  gcd_o
);
  import frgcd_pkg::*;

  // Binary gcd, one step per cycle; operands must both be nonzero.
  logic [WIDTH-1:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             u_gt_v;
  logic [WIDTH-1:0] diff;

  assign u_gt_v = u_q > v_q;
  assign diff   = u_gt_v ? (u_q - v_q) : (v_q - u_q);

  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      u_d    = a_i;
      v_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q == '0) begin
        g_d    = u_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!u_q[0] && !v_q[0]) begin
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        k_d = k_q + CNT_W'(1);
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else begin
        if (u_gt_v) begin
          u_d = v_q;
        end
        v_d = diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign gcd_o       = g_q;

endmodule

/* hw/rtl/frgcd_div.sv */
module frgcd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [frgcd_pkg::WIDTH-1:0]  dividend_i,
  input  logic [frgcd_pkg::WIDTH-1:0]  divisor_i,
  output frgcd_pkg::unit_stat_t        stat_o,
  output logic [frgcd_pkg::WIDTH-1:0]  quot_o
);
  import frgcd_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  // Restoring division, one quotient bit per cycle.
  logic [WIDTH-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WIDTH:0]   rem_sh, dvs_ext, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[WIDTH-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = rem_sh >= dvs_ext;
  assign rem_sub = rem_sh - dvs_ext;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

/* hw/rtl/fraction_reduce_gcd_core.sv */
// An item with a zero operand goes straight to the done state; otherwise the
// binary gcd runs first and the one divider then forms the two quotients,
// numerator by gcd and then denominator by gcd.
// Throughput: one item at a time, next accept in the cycle after the result loads;
// in_stall_o is high from accept until the result moves into the output register,
// which waits while an older item there is stalled.
module fraction_reduce_gcd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [frgcd_pkg::WIDTH-1:0]   num_in_i,
  input  logic [frgcd_pkg::WIDTH-1:0]   den_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [frgcd_pkg::WIDTH-1:0]   num_out_o,
  output logic [frgcd_pkg::WIDTH-2:0]   den_out_o
);
  import frgcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVA,
    S_DIVB,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [WIDTH-1:0] a_q, b_q, qa_q, res_num_q, num_out_q;
  logic [WIDTH-2:0] res_den_q, den_out_q;
  logic             neg_q, gcd_start_q, div_start_q, out_valid_q;
  logic [WIDTH-1:0] a_in, b_in, gcd, quot, dividend;
  logic             in_acc, out_free;
  unit_stat_t       gcd_stat, div_stat;

  assign a_in     = magnitude(num_in_i);
  assign b_in     = magnitude(den_in_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign dividend = (state_q == S_DIVB) ? b_q : a_q;

  frgcd_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .stat_o  (gcd_stat),
    .gcd_o   (gcd)
  );

  frgcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dividend),
    .divisor_i  (gcd),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gcd_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gcd_start_q <= (state_q == S_IDLE) && in_acc && (a_in != '0) && (b_in != '0);
      div_start_q <= (state_q == S_GCD && gcd_stat.done) ||
                     (state_q == S_DIVA && div_stat.done);
      out_valid_q <= (state_q == S_DONE && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (a_in == '0 || b_in == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            state_q <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_stat.done) begin
            state_q <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_stat.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q       <= a_in;
      b_q       <= b_in;
      neg_q     <= num_in_i[WIDTH-1] ^ den_in_i[WIDTH-1];
      res_num_q <= '0;
      res_den_q <= (a_in == '0 && b_in != '0) ? (WIDTH-1)'(1) : '0;
    end
    if (state_q == S_DIVA && div_stat.done) begin
      qa_q <= quot;
    end
    if (state_q == S_DIVB && div_stat.done) begin
      res_num_q <= neg_q ? (~qa_q + WIDTH'(1)) : qa_q;
      res_den_q <= quot[WIDTH-2:0];
    end
    if (state_q == S_DONE && out_free) begin
      num_out_q <= res_num_q;
      den_out_q <= res_den_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign num_out_o   = num_out_q;
  assign den_out_o   = den_out_q;

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted item did not make the block busy");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gcd_stat.busy && div_stat.busy))
    else $error("gcd and divider busy together");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (state_q == S_DIVA || state_q == S_DIVB))
    else $error("divider started outside a divide phase");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented without completing an item");

endmodule

/* sim/fraction_reduce_gcd_core_tb.sv */
module fraction_reduce_gcd_core_tb;

  localparam int unsigned W = frgcd_pkg::WIDTH;
  localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-2:0] den;
  } frac_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] num_in_i = '0;
  logic [W-1:0] den_in_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] num_out_o;
  logic [W-2:0] den_out_o;

  frac_t       reduced_q[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  fraction_reduce_gcd_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .num_in_i    (num_in_i),
    .den_in_i    (den_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .num_out_o   (num_out_o),
    .den_out_o   (den_out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic frac_t reduce_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] r;
    int           sn;
    int           sd;
    frac_t        res;
    sn = (n == '0) ? 0 : (n[W-1] ? -1 : 1);
    sd = (d == '0) ? 0 : (d[W-1] ? -1 : 1);
    a = n[W-1] ? (~n + 1'b1) : n;
    b = d[W-1] ? (~d + 1'b1) : d;
    x = a;
    y = b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (x != '0) begin
      a = a / x;
      b = b / x;
    end
    if (sn * sd < 0) begin
      res.num = ~a + 1'b1;
    end else if (sn * sd == 0) begin
      res.num = '0;
    end else begin
      res.num = a;
    end
    res.den = b[W-2:0];
    return res;
  endfunction

  function automatic logic [W-1:0] apply_sign(input logic [W-1:0] mag);
    return $urandom_range(1) ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [W-1:0] any_value();
    logic [W-1:0] v;
    v = $urandom;
    while (v == MIN_NEG) v = $urandom;
    return v;
  endfunction

  task automatic send_item(input logic [W-1:0] n, input logic [W-1:0] d);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    num_in_i   <= n;
    den_in_i   <= d;
    do @(posedge clk_i); while (in_stall_o);
    reduced_q.push_back(reduce_fraction(n, d));
  endtask

  // result check and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected item num %h den %h", $time, num_out_o, den_out_o);
        mismatches++;
      end else begin
        frac_t exp_f;
        exp_f = reduced_q.pop_front();
        if (num_out_o !== exp_f.num) begin
          $display("%0t: num_out expected %h actual %h", $time, exp_f.num, num_out_o);
          mismatches++;
        end
        if (den_out_o !== exp_f.den) begin
          $display("%0t: den_out expected %h actual %h", $time, exp_f.den, den_out_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_edge_values();
    send_item('0, '0);
    send_item('0, 32'd5);
    send_item('0, -32'sd5);
    send_item(32'd7, '0);
    send_item(-32'sd7, '0);
    send_item(32'd1, 32'd1);
    send_item(-32'sd1, 32'd1);
    send_item(32'd1, -32'sd1);
    send_item(-32'sd1, -32'sd1);
    send_item(MAX_MAG, MAX_MAG);
    send_item(~MAX_MAG + 1'b1, MAX_MAG);
    send_item(MAX_MAG, 32'd1);
    send_item(32'd1, MAX_MAG);
    send_item(MAX_MAG, -32'sd1);
    send_item(~MAX_MAG + 1'b1, ~MAX_MAG + 1'b1);
    send_item(32'd6, 32'd4);
    send_item(-32'sd6, 32'd4);
    send_item(32'd6, -32'sd4);
    send_item(-32'sd6, -32'sd4);
    send_item(32'd1073741824, 32'd536870912);
    send_item(32'd2147483646, 32'd1073741823);
    send_item(32'd2147483629, 32'd2147483587);
    send_item(-32'sd36, 32'd24);
    send_item(32'd12, 32'd12);
  endtask

  // shared factor of up to 2**20 so the divisions do real work
  task automatic test_common_factors(input int unsigned count);
    logic [W-1:0] g;
    logic [W-1:0] a;
    logic [W-1:0] b;
    repeat (count) begin
      g = $urandom_range(1, 1 << $urandom_range(1, 20));
      a = $urandom_range(0, MAX_MAG / g);
      b = $urandom_range(0, MAX_MAG / g);
      send_item(apply_sign(a * g), apply_sign(b * g));
    end
  endtask

  task automatic test_full_range(input int unsigned count);
    repeat (count) send_item(any_value(), any_value());
  endtask

  task automatic test_small_values(input int unsigned count);
    repeat (count) begin
      send_item(apply_sign($urandom_range(0, 40)), apply_sign($urandom_range(0, 40)));
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    steady = 1'b1;
    test_common_factors(count / 2);
    test_full_range(count - count / 2);
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_common_factors(600);
    test_full_range(450);
    test_small_values(350);
    test_back_to_back(250);
    in_valid_i <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
